// ===== rtl/core/lcfs_pkg.sv =====
// Shared types, register map, check codes and counter helpers for the fault supervisor.
package lcfs_pkg;

    // Sample width of the ADC fields and the ADC-valued registers.
    localparam int ADC_BITS = 12;

    // Configuration port geometry.
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int PADDR_W    = REG_IDX_W + 2;
    localparam int PDATA_W    = 32;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_CHECK_ENABLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THERM_LIMIT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MOTOR_VOLT_LOW = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MOTOR_VOLT_HI  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOGIC_VOLT_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_THERMAL_TRIP   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_TRIP   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ENCODER_TRIP   = 3'd7;

    // Bit positions shared by check_enable and the sticky error flags.
    localparam int EN_LIMIT = 0;
    localparam int EN_THERM = 1;
    localparam int EN_MOTOR = 2;
    localparam int EN_LOGIC = 3;
    localparam int EN_ENC   = 4;
    localparam int EN_AMP   = 5;

    // Trip cause codes.
    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_LIMIT   = 3'd1;
    localparam logic [2:0] CAUSE_THERMAL = 3'd2;
    localparam logic [2:0] CAUSE_MOTOR   = 3'd3;
    localparam logic [2:0] CAUSE_LOGIC   = 3'd4;
    localparam logic [2:0] CAUSE_ENCODER = 3'd5;

    // Register reset values.
    localparam logic [5:0]  CHECK_ENABLE_RST   = 6'd63;
    localparam logic [7:0]  THERMAL_TRIP_RST   = 8'd100;
    localparam logic [15:0] VOLTAGE_TRIP_RST   = 16'd500;
    localparam logic [7:0]  ENCODER_TRIP_RST   = 8'd10;

    // Input item.
    typedef struct packed {
        logic                mode;
        logic [7:0]          limit_switches;
        logic [ADC_BITS-1:0] therm_a;
        logic [ADC_BITS-1:0] therm_b;
        logic [ADC_BITS-1:0] therm_c;
        logic [ADC_BITS-1:0] therm_d;
        logic [ADC_BITS-1:0] therm_e;
        logic [ADC_BITS-1:0] therm_f;
        logic [ADC_BITS-1:0] motor_volt;
        logic [ADC_BITS-1:0] logic_volt;
        logic [1:0]          encoder_invalid;
        logic [1:0]          amp_fault;
    } lcfs_in_t;

    // Result item.
    typedef struct packed {
        logic       fault;
        logic [5:0] error_flags;
        logic [2:0] trip_cause;
    } lcfs_out_t;

    // Configuration register contents.
    typedef struct packed {
        logic [5:0]          check_enable;
        logic [ADC_BITS-1:0] thermistor_limit;
        logic [ADC_BITS-1:0] motor_volt_low;
        logic [ADC_BITS-1:0] motor_volt_high;
        logic [ADC_BITS-1:0] logic_volt_min;
        logic [7:0]          thermal_trip_count;
        logic [15:0]         voltage_trip_count;
        logic [7:0]          encoder_trip_count;
    } lcfs_cfg_t;

    // Saturating up / floored down step of an 8-bit leaky counter.
    function automatic logic [7:0] leak_8(input logic [7:0] cnt, input logic up);
        logic [7:0] res;
        begin
            if (up)
            begin
                res = (cnt == 8'hFF) ? cnt : cnt + 8'd1;
            end
            else
            begin
                res = (cnt == 8'h00) ? cnt : cnt - 8'd1;
            end
            return res;
        end
    endfunction

    // Saturating up / floored down step of a 16-bit leaky counter.
    function automatic logic [15:0] leak_16(input logic [15:0] cnt, input logic up);
        logic [15:0] res;
        begin
            if (up)
            begin
                res = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
            end
            else
            begin
                res = (cnt == 16'h0000) ? cnt : cnt - 16'd1;
            end
            return res;
        end
    endfunction

endpackage

// ===== rtl/core/lcfs_regs.sv =====
// APB-style configuration register file for the fault supervisor.
module lcfs_regs
    import lcfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output lcfs_cfg_t          cfg
);

    lcfs_cfg_t             cfg_reg;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes complete in the access phase of a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_enable       <= CHECK_ENABLE_RST;
            cfg_reg.thermistor_limit   <= '0;
            cfg_reg.motor_volt_low     <= '0;
            cfg_reg.motor_volt_high    <= '0;
            cfg_reg.logic_volt_min     <= '0;
            cfg_reg.thermal_trip_count <= THERMAL_TRIP_RST;
            cfg_reg.voltage_trip_count <= VOLTAGE_TRIP_RST;
            cfg_reg.encoder_trip_count <= ENCODER_TRIP_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CHECK_ENABLE:   cfg_reg.check_enable       <= pwdata[5:0];
                REG_THERM_LIMIT:    cfg_reg.thermistor_limit   <= pwdata[ADC_BITS-1:0];
                REG_MOTOR_VOLT_LOW: cfg_reg.motor_volt_low     <= pwdata[ADC_BITS-1:0];
                REG_MOTOR_VOLT_HI:  cfg_reg.motor_volt_high    <= pwdata[ADC_BITS-1:0];
                REG_LOGIC_VOLT_MIN: cfg_reg.logic_volt_min     <= pwdata[ADC_BITS-1:0];
                REG_THERMAL_TRIP:   cfg_reg.thermal_trip_count <= pwdata[7:0];
                REG_VOLTAGE_TRIP:   cfg_reg.voltage_trip_count <= pwdata[15:0];
                REG_ENCODER_TRIP:   cfg_reg.encoder_trip_count <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // Read data is the addressed register, zero-extended.
    always_comb
    begin
        unique case (reg_idx)
            REG_CHECK_ENABLE:   prdata = PDATA_W'(cfg_reg.check_enable);
            REG_THERM_LIMIT:    prdata = PDATA_W'(cfg_reg.thermistor_limit);
            REG_MOTOR_VOLT_LOW: prdata = PDATA_W'(cfg_reg.motor_volt_low);
            REG_MOTOR_VOLT_HI:  prdata = PDATA_W'(cfg_reg.motor_volt_high);
            REG_LOGIC_VOLT_MIN: prdata = PDATA_W'(cfg_reg.logic_volt_min);
            REG_THERMAL_TRIP:   prdata = PDATA_W'(cfg_reg.thermal_trip_count);
            REG_VOLTAGE_TRIP:   prdata = PDATA_W'(cfg_reg.voltage_trip_count);
            REG_ENCODER_TRIP:   prdata = PDATA_W'(cfg_reg.encoder_trip_count);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/lcfs_check.sv =====
// Check chain, leaky counters and sticky flags of the fault supervisor.
module lcfs_check
    import lcfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  lcfs_in_t  item,
    input  lcfs_cfg_t cfg,
    output lcfs_out_t result
);

    logic [7:0]  thermal_count_reg,    thermal_count_next;
    logic [15:0] motor_volt_count_reg, motor_volt_count_next;
    logic [15:0] logic_volt_count_reg, logic_volt_count_next;
    logic [7:0]  motor_enc_reg,        motor_enc_next;
    logic [7:0]  leg_enc_reg,          leg_enc_next;
    logic [5:0]  sticky_reg,           sticky_next;

    logic        hot;
    logic        band;
    logic        undervolt;
    logic [7:0]  therm_step;
    logic [15:0] motor_step;
    logic [15:0] logic_step;
    logic        trip_limit;
    logic        run_therm;
    logic        trip_therm;
    logic        run_motor;
    logic        trip_motor;
    logic        run_logic;
    logic        trip_logic;
    logic        trip_enc;
    logic [2:0]  cause;
    logic [5:0]  flags_enc;

    // Sample comparisons against the configured limits.
    always_comb
    begin
        hot = (item.therm_a < cfg.thermistor_limit) || (item.therm_b < cfg.thermistor_limit) ||
              (item.therm_c < cfg.thermistor_limit) || (item.therm_d < cfg.thermistor_limit) ||
              (item.therm_e < cfg.thermistor_limit) || (item.therm_f < cfg.thermistor_limit);
        band      = (item.motor_volt < cfg.motor_volt_high) &&
                    (item.motor_volt > cfg.motor_volt_low);
        undervolt = item.logic_volt < cfg.logic_volt_min;
    end

    // Encoder counters bump first; the encoder check then sees the new values.
    always_comb
    begin
        motor_enc_next = item.encoder_invalid[0] ? leak_8(motor_enc_reg, 1'b1) : motor_enc_reg;
        leg_enc_next   = item.encoder_invalid[1] ? leak_8(leg_enc_reg, 1'b1) : leg_enc_reg;
        flags_enc      = sticky_reg;
        if (item.encoder_invalid != 2'b00)
        begin
            flags_enc[EN_ENC] = 1'b1;
        end
    end

    // Ordered check chain: a check runs only when it is enabled and none before it tripped.
    always_comb
    begin
        therm_step = leak_8(thermal_count_reg, hot);
        motor_step = leak_16(motor_volt_count_reg, band);
        logic_step = leak_16(logic_volt_count_reg, undervolt);

        trip_limit = cfg.check_enable[EN_LIMIT] && (item.limit_switches != 8'd0);
        run_therm  = !trip_limit && cfg.check_enable[EN_THERM];
        trip_therm = run_therm && (therm_step > cfg.thermal_trip_count);
        run_motor  = !trip_limit && !trip_therm && cfg.check_enable[EN_MOTOR];
        trip_motor = run_motor && (motor_step > cfg.voltage_trip_count);
        run_logic  = !trip_limit && !trip_therm && !trip_motor && cfg.check_enable[EN_LOGIC];
        trip_logic = run_logic && (logic_step > cfg.voltage_trip_count);
        trip_enc   = !trip_limit && !trip_therm && !trip_motor && !trip_logic &&
                     cfg.check_enable[EN_ENC] &&
                     ((motor_enc_next > cfg.encoder_trip_count) ||
                      (leg_enc_next > cfg.encoder_trip_count));

        priority if (trip_limit) cause = CAUSE_LIMIT;
        else if (trip_therm)     cause = CAUSE_THERMAL;
        else if (trip_motor)     cause = CAUSE_MOTOR;
        else if (trip_logic)     cause = CAUSE_LOGIC;
        else if (trip_enc)       cause = CAUSE_ENCODER;
        else                     cause = CAUSE_NONE;
    end

    // Next state and the result of this item; clear mode zeroes everything.
    always_comb
    begin
        thermal_count_next    = run_therm ? therm_step : thermal_count_reg;
        motor_volt_count_next = run_motor ? motor_step : motor_volt_count_reg;
        logic_volt_count_next = run_logic ? logic_step : logic_volt_count_reg;
        sticky_next           = flags_enc;
        if (trip_limit)
        begin
            sticky_next[EN_LIMIT] = 1'b1;
        end
        if (trip_therm)
        begin
            sticky_next[EN_THERM] = 1'b1;
        end
        if (trip_motor)
        begin
            sticky_next[EN_MOTOR] = 1'b1;
        end
        if (trip_logic)
        begin
            sticky_next[EN_LOGIC] = 1'b1;
        end
        if (trip_enc)
        begin
            sticky_next[EN_ENC] = 1'b1;
        end
        if ((cause == CAUSE_NONE) && cfg.check_enable[EN_AMP] && (item.amp_fault != 2'b00))
        begin
            sticky_next[EN_AMP] = 1'b1;
        end

        result.fault       = (cause != CAUSE_NONE);
        result.error_flags = sticky_next;
        result.trip_cause  = cause;

        if (item.mode)
        begin
            thermal_count_next    = '0;
            motor_volt_count_next = '0;
            logic_volt_count_next = '0;
            sticky_next           = '0;
            result                = '0;
        end
    end

    // State advances once for every item that is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thermal_count_reg    <= '0;
            motor_volt_count_reg <= '0;
            logic_volt_count_reg <= '0;
            motor_enc_reg        <= '0;
            leg_enc_reg          <= '0;
            sticky_reg           <= '0;
        end
        else if (fire)
        begin
            thermal_count_reg    <= thermal_count_next;
            motor_volt_count_reg <= motor_volt_count_next;
            logic_volt_count_reg <= logic_volt_count_next;
            motor_enc_reg        <= item.mode ? 8'd0 : motor_enc_next;
            leg_enc_reg          <= item.mode ? 8'd0 : leg_enc_next;
            sticky_reg           <= sticky_next;
        end
    end

endmodule

// ===== rtl/core/leaky_counter_fault_supervisor_unit.sv =====
// Top level of the leaky-counter fault supervisor: input register, check chain, result register.
// Flow: an accepted transfer is held in the input register, evaluated by the check chain, and
// its result is loaded into the result register and presented on the output channel.
// Throughput: one item per cycle while the output is not stalled; all checks and counter updates
// sit between the input and result registers, and the counters update when the result is registered.
// Reset: rst_n clears all counters, sticky flags and valid bits and loads register defaults.
module leaky_counter_fault_supervisor_unit
    import lcfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcfs_in_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lcfs_out_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    lcfs_cfg_t  cfg;
    lcfs_in_t   item_reg;
    logic       item_valid_reg;
    lcfs_out_t  result;
    lcfs_out_t  out_data_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       fire;

    lcfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcfs_check u_check (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // The held item moves on whenever the result register is free or being emptied.
    assign advance   = !out_valid_reg || out_ready;
    assign fire      = item_valid_reg && advance;
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Input register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    // Result register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/lcfs_checker.sv =====
// Port-level assertions for the fault supervisor and their bind to the top level.
module lcfs_checker
    import lcfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_ready,
    input  logic      out_valid,
    input  logic      out_ready,
    input  lcfs_out_t out_data
);

    // An idle output side always leaves room for a new input transfer.
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output side is empty");

    // Fault is raised exactly when a trip cause is reported.
    a_fault_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.fault == (out_data.trip_cause != CAUSE_NONE)))
        else $error("fault and trip cause disagree");

    // A reported cause is a known code and its sticky flag is set.
    a_cause_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fault |->
            (out_data.trip_cause <= CAUSE_ENCODER) &&
            (((out_data.error_flags >> (out_data.trip_cause - 3'd1)) & 6'd1) == 6'd1))
        else $error("trip cause without its sticky flag");

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

endmodule

bind leaky_counter_fault_supervisor_unit lcfs_checker u_lcfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
